// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertion helpers for the frequency shifter, used by hilbert_frequency_shifter
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define HFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define HFS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== design/hfs_pkg.sv =====
// ----------------------------------------------------------------------------
// hfs_pkg
// types, constants, coefficient and sine tables for the frequency shifter
// ----------------------------------------------------------------------------
`default_nettype none

package hfs_pkg;

  // sizes
  localparam int CHANNELS      = 2;
  localparam int SECTIONS      = 4;
  localparam int PHASE_BITS    = 24;
  localparam int SAMPLE_BITS   = 24;
  localparam int INNER_BITS    = SAMPLE_BITS + 4;
  localparam int ENTRY_BITS    = 2 * INNER_BITS;
  localparam int SLOTS         = CHANNELS * 2 * SECTIONS;
  localparam int SLOT_BITS     = $clog2(SLOTS);
  localparam int CH_BITS       = $clog2(CHANNELS);
  localparam int STEP_BITS     = $clog2(2 * SECTIONS);
  localparam int SEC_BITS      = $clog2(SECTIONS);
  localparam int ACTIVE_BITS   = 2;
  localparam int TDATA_BITS    = CHANNELS * SAMPLE_BITS;

  // configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 24;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_INC     = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 1'd1;
  localparam int CC_BITS = 2;

  // arithmetic widths
  localparam int COEF_BITS  = 25;
  localparam int DIFF_BITS  = INNER_BITS + 1;
  localparam int TRIG_BITS  = 25;
  localparam int PROD_BITS  = COEF_BITS + DIFF_BITS;
  localparam int MIX_BITS   = INNER_BITS + TRIG_BITS;
  localparam int SEC_SHIFT  = 24;
  localparam int MIX_SHIFT  = 23;
  localparam int SEC_P_BITS = PROD_BITS - SEC_SHIFT;
  localparam int WIDE_BITS  = PROD_BITS - MIX_SHIFT;
  localparam logic signed [PROD_BITS-1:0] SEC_HALF = PROD_BITS'(1) << (SEC_SHIFT - 1);
  localparam logic signed [PROD_BITS-1:0] MIX_HALF = PROD_BITS'(1) << (MIX_SHIFT - 1);
  localparam logic signed [TRIG_BITS-1:0] TRIG_ONE = TRIG_BITS'(1) << (SAMPLE_BITS - 1);

  // sine table
  localparam int SINE_DEPTH     = 1024;
  localparam int SINE_IDX_BITS  = $clog2(SINE_DEPTH);
  localparam int SINE_ADDR_BITS = SINE_IDX_BITS + 1;
  localparam int SINE_BITS      = SAMPLE_BITS;
  localparam int QUARTER_SHIFT  = PHASE_BITS - 2;
  localparam int SERIES_TERMS   = 12;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // allpass coefficients, Q0.24
  typedef logic signed [COEF_BITS-1:0] coef_tab_t [SECTIONS];
  localparam coef_tab_t COEF_A = '{25'sd8043012, 25'sd14700507, 25'sd16384589, 25'sd16735260};
  localparam coef_tab_t COEF_B = '{25'sd2713857, 25'sd12298185, 25'sd15860336, 25'sd16619496};

  typedef logic [SINE_BITS-1:0] sine_tab_t [SINE_DEPTH + 1];

  // unsigned shift and subtract division, only used while building the table
  function automatic longint unsigned div_u64(
    input longint unsigned num,
    input longint unsigned den
  );
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // quarter-wave sine from the integer taylor series, rounded to Q23
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t         tab;
    longint unsigned   x;
    longint unsigned   term;
    longint            sum;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * 64'(k) + SINE_DEPTH / 2) / SINE_DEPTH;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= SERIES_TERMS; n++) begin
        term = ((term * x) >> 30) * x >> 30;
        term = div_u64(term, 64'(2 * n) * 64'(2 * n + 1));
        if ((n & 1) != 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      sum = (sum + 64) >>> 7;
      if (sum > 8388608) begin
        sum = 8388608;
      end
      tab[k] = SINE_BITS'(sum);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // saturate a wide value to the inner filter width
  function automatic logic signed [INNER_BITS-1:0] sat_inner(
    input logic signed [WIDE_BITS-1:0] v
  );
    if (v[WIDE_BITS-1:INNER_BITS-1] == '0 || v[WIDE_BITS-1:INNER_BITS-1] == '1) begin
      return v[INNER_BITS-1:0];
    end else if (v[WIDE_BITS-1]) begin
      return {1'b1, {(INNER_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(INNER_BITS-1){1'b1}}};
    end
  endfunction

  // saturate a wide value to the sample width
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [WIDE_BITS-1:0] v
  );
    if (v[WIDE_BITS-1:SAMPLE_BITS-1] == '0 || v[WIDE_BITS-1:SAMPLE_BITS-1] == '1) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[WIDE_BITS-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIG_S,
    ST_TRIG_C,
    ST_TRIG_W,
    ST_SEC_RD,
    ST_SEC_MUL,
    ST_SEC_ADD,
    ST_MIX_A,
    ST_MIX_B,
    ST_MIX_R,
    ST_DONE
  } state_t;

  // datapath controls decoded from the state
  typedef struct packed {
    logic in_ready;
    logic trig_rd;
    logic cap_sin;
    logic cap_cos;
    logic rd_en;
    logic rd_next;
    logic sec_mul;
    logic sec_add;
    logic mix_a;
    logic mix_b;
    logic mix_r;
    logic out_load;
  } ctl_t;

endpackage

`default_nettype wire

// ===== design/hilbert_frequency_shifter.sv =====
// ----------------------------------------------------------------------------
// hilbert_frequency_shifter
// stereo frequency shifter: allpass hilbert pair per channel, quadrature mix
// ----------------------------------------------------------------------------
// Sine and cosine come from one table port in the states TRIG_S, TRIG_C and
// TRIG_W. Each shifted channel then reads its first section state and runs
// each of its eight allpass sections as a multiply step, then an add and
// write back step while the next section state is read, through a one-read
// one-write state ram, followed by quadrature mixing in MIX_A, MIX_B and
// MIX_R. The next item is taken as soon as the previous result sits in the
// output register, so a stalled output costs nothing until the next result
// is ready. After reset every section state reads as zero.
`default_nettype none
`include "assert_macros.svh"

module hilbert_frequency_shifter (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [hfs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [hfs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // input items
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [hfs_pkg::TDATA_BITS-1:0]      s_tdata,   // sample_left, sample_right
  // result items
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [hfs_pkg::TDATA_BITS-1:0]      m_tdata    // out_left, out_right
);

  import hfs_pkg::*;

  state_t state, state_next;
  ctl_t   ctl;

  logic [PHASE_BITS-1:0]  phase_inc;
  logic [CC_BITS-1:0]     channel_count;
  logic [PHASE_BITS-1:0]  phase;
  logic [ACTIVE_BITS-1:0] active;
  logic [CH_BITS-1:0]     ch;
  logic [STEP_BITS-1:0]   step;
  logic                   last_step;
  logic                   more_ch;

  logic signed [SAMPLE_BITS-1:0] samples [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] res     [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] out_data [CHANNELS];

  // oscillator
  logic [1:0]                quad_s, quad_c, quad_rd;
  logic [SINE_IDX_BITS-1:0]  sine_idx;
  logic [SINE_ADDR_BITS-1:0] rom_addr;
  logic [SINE_BITS-1:0]      rom_q;
  logic signed [TRIG_BITS-1:0] rom_val;
  logic signed [TRIG_BITS-1:0] sn, cs;

  // section datapath
  logic [SLOT_BITS-1:0]   rd_addr, wr_addr;
  logic [ENTRY_BITS-1:0]  ram_q;
  logic [SLOTS-1:0]       slot_vld;
  logic                   slot_vld_q;
  logic signed [INNER_BITS-1:0] xp, yp, x, a_res, y;
  logic signed [DIFF_BITS-1:0]  diff;
  logic signed [COEF_BITS-1:0]  coef;
  logic signed [PROD_BITS-1:0]  sec_prod, prod, acc, sec_rnd;
  logic signed [SEC_P_BITS-1:0] sec_p;
  logic signed [WIDE_BITS-1:0]  sec_sum;

  // mixer
  logic signed [INNER_BITS-1:0] mix_lhs;
  logic signed [TRIG_BITS-1:0]  mix_rhs;
  logic signed [MIX_BITS-1:0]   mix_prod;
  logic signed [PROD_BITS-1:0]  mix_total, mix_rnd;
  logic signed [WIDE_BITS-1:0]  mix_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_inc     <= '0;
      channel_count <= CC_BITS'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_INC:     phase_inc     <= cfg_data[PHASE_BITS-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer flags
  assign last_step = (step == STEP_BITS'(2 * SECTIONS - 1));
  assign more_ch   = ((ACTIVE_BITS'(ch) + ACTIVE_BITS'(1)) < active);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (s_tvalid) state_next = ST_TRIG_S;
      ST_TRIG_S:  state_next = ST_TRIG_C;
      ST_TRIG_C:  state_next = ST_TRIG_W;
      ST_TRIG_W:  state_next = (active != '0) ? ST_SEC_RD : ST_DONE;
      ST_SEC_RD:  state_next = ST_SEC_MUL;
      ST_SEC_MUL: state_next = ST_SEC_ADD;
      ST_SEC_ADD: state_next = last_step ? ST_MIX_A : ST_SEC_MUL;
      ST_MIX_A:   state_next = ST_MIX_B;
      ST_MIX_B:   state_next = ST_MIX_R;
      ST_MIX_R:   state_next = more_ch ? ST_SEC_RD : ST_DONE;
      ST_DONE:    if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE:    ctl.in_ready = 1'b1;
      ST_TRIG_S:  ctl.trig_rd  = 1'b1;
      ST_TRIG_C: begin
        ctl.trig_rd = 1'b1;
        ctl.cap_sin = 1'b1;
      end
      ST_TRIG_W:  ctl.cap_cos = 1'b1;
      ST_SEC_RD:  ctl.rd_en   = 1'b1;
      ST_SEC_MUL: ctl.sec_mul = 1'b1;
      ST_SEC_ADD: begin
        ctl.sec_add = 1'b1;
        ctl.rd_en   = !last_step;
        ctl.rd_next = 1'b1;
      end
      ST_MIX_A:   ctl.mix_a = 1'b1;
      ST_MIX_B:   ctl.mix_b = 1'b1;
      ST_MIX_R:   ctl.mix_r = 1'b1;
      ST_DONE:    ctl.out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = ctl.in_ready;

  // item capture and phase advance
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= '0;
      active <= '0;
    end else if (s_tvalid && ctl.in_ready) begin
      phase <= phase + phase_inc;
      if (channel_count == CC_BITS'(0)) begin
        active <= ACTIVE_BITS'(0);
      end else if (channel_count == CC_BITS'(1)) begin
        active <= ACTIVE_BITS'(1);
      end else begin
        active <= ACTIVE_BITS'(CHANNELS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && ctl.in_ready) begin
      for (int c = 0; c < CHANNELS; c++) begin
        samples[c] <= s_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
  end

  // quarter-wave lookup: sine first, cosine a quarter turn later
  assign quad_s   = phase[PHASE_BITS-1 -: 2];
  assign quad_c   = quad_s + 2'd1;
  assign quad_rd  = ctl.cap_sin ? quad_c : quad_s;
  assign sine_idx = phase[QUARTER_SHIFT-1 -: SINE_IDX_BITS];
  assign rom_addr = quad_rd[0] ? (SINE_ADDR_BITS'(SINE_DEPTH) - SINE_ADDR_BITS'(sine_idx))
                               : SINE_ADDR_BITS'(sine_idx);

  always_ff @(posedge clk) begin
    if (ctl.trig_rd) begin
      rom_q <= SINE_TAB[rom_addr];
    end
  end

  assign rom_val = $signed({1'b0, rom_q});

  always_ff @(posedge clk) begin
    if (ctl.cap_sin) begin
      sn <= quad_s[1] ? -rom_val : rom_val;
    end
    if (ctl.cap_cos) begin
      cs <= quad_c[1] ? -rom_val : rom_val;
    end
  end

  // section state ram: entry holds prior input over prior output
  assign rd_addr = ctl.rd_next ? {ch, step + STEP_BITS'(1)} : {ch, step};
  assign wr_addr = {ch, step};

  hfs_state_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (SLOTS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ctl.sec_add),
    .waddr (wr_addr),
    .wdata ({x, y}),
    .re    (ctl.rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
    end else if (ctl.sec_add) begin
      slot_vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      slot_vld_q <= slot_vld[rd_addr];
    end
  end

  assign xp = slot_vld_q ? $signed(ram_q[ENTRY_BITS-1:INNER_BITS]) : '0;
  assign yp = slot_vld_q ? $signed(ram_q[INNER_BITS-1:0]) : '0;

  // allpass section: y = x_prev + a * (y_prev - x)
  assign coef     = step[STEP_BITS-1] ? COEF_B[step[SEC_BITS-1:0]] : COEF_A[step[SEC_BITS-1:0]];
  assign diff     = DIFF_BITS'(yp) - DIFF_BITS'(x);
  assign sec_prod = coef * diff;
  assign sec_rnd  = prod + SEC_HALF;
  assign sec_p    = sec_rnd[PROD_BITS-1:SEC_SHIFT];
  assign sec_sum  = WIDE_BITS'(sec_p) + WIDE_BITS'(xp);
  assign y        = sat_inner(sec_sum);

  // quadrature mix, one product a cycle
  assign mix_lhs   = ctl.mix_b ? x : a_res;
  assign mix_rhs   = ctl.mix_b ? sn : cs;
  assign mix_prod  = mix_lhs * mix_rhs;
  assign mix_total = acc + prod;
  assign mix_rnd   = mix_total + MIX_HALF;
  assign mix_r     = mix_rnd[PROD_BITS-1:MIX_SHIFT];

  // channel and section counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ch   <= '0;
      step <= '0;
    end else if (ctl.cap_cos) begin
      ch   <= '0;
      step <= '0;
    end else if (ctl.sec_add) begin
      step <= step + STEP_BITS'(1);
    end else if (ctl.mix_r && more_ch) begin
      ch   <= ch + CH_BITS'(1);
      step <= '0;
    end
  end

  // filter datapath registers
  always_ff @(posedge clk) begin
    if (ctl.cap_cos) begin
      x <= INNER_BITS'(samples[0]);
    end else if (ctl.sec_add) begin
      // chain b restarts from the channel sample
      if (step == STEP_BITS'(SECTIONS - 1)) begin
        x     <= INNER_BITS'(samples[ch]);
        a_res <= y;
      end else begin
        x <= y;
      end
    end else if (ctl.mix_r) begin
      x <= INNER_BITS'(samples[ch + CH_BITS'(1)]);
    end
    if (ctl.sec_mul) begin
      prod <= sec_prod;
    end else if (ctl.mix_a || ctl.mix_b) begin
      prod <= PROD_BITS'(mix_prod);
    end
    if (ctl.mix_b) begin
      acc <= prod;
    end
    if (ctl.mix_r) begin
      res[ch] <= sat_sample(mix_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      for (int c = 0; c < CHANNELS; c++) begin
        out_data[c] <= (ACTIVE_BITS'(c) < active) ? res[c] : samples[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      m_tdata[c*SAMPLE_BITS +: SAMPLE_BITS] = out_data[c];
    end
  end

  // checks
  `HFS_ASSERT(a_accept_starts, s_tvalid && s_tready |=> state == ST_TRIG_S, "accept did not start trig")
  `HFS_ASSERT(a_out_from_done, $rose(m_tvalid) |-> $past(state) == ST_DONE, "result outside done")
  `HFS_NEVER(a_wr_active, ctl.sec_add && (ACTIVE_BITS'(ch) >= active), "write to passed channel")
  `HFS_ASSERT(a_sin_range, ctl.cap_sin |=> (sn <= TRIG_ONE) && (sn >= -TRIG_ONE), "sine out of range")

endmodule

`default_nettype wire

// ===== design/hfs_state_ram.sv =====
// ----------------------------------------------------------------------------
// hfs_state_ram
// simple dual-address ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hfs_state_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
